[rtl/assert_macros.svh]
// Assertion macros shared by the filter RTL.
// Included by every file that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising clock edge outside reset.
`define TSPF_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tspf assertion failed");

// Check prop at every rising clock edge, reset included.
`define TSPF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("tspf assertion failed");

`else

`define TSPF_ASSERT_CLK(label, clk, rst_n, prop)
`define TSPF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[rtl/tspf_pkg.sv]
// Package of the transport-stream PID filter: widths, codes and the queue entry type.
// No dependencies; used by the interfaces and by every module.
package tspf_pkg;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int OFFS_W   = 31;
    localparam int BASE_W   = 32;
    localparam int PID_W    = 13;
    localparam int PIDREG_W = 14;
    localparam int IDX_W    = 8;
    localparam int CFG_IDX_W = 4;

    // Defaults for the top-level parameters
    localparam int unsigned PACKET_BYTES_DEF = 188;
    localparam logic [BASE_W-1:0] MAX_LENGTH_DEF = 32'd2097152000;

    // Configured PID registers
    localparam int PID_COUNT = 8;
    localparam logic [PIDREG_W-1:0] PID_DISABLED = '1;

    // Stream constants
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h47;
    localparam logic [PID_W-1:0]  PID_PAT   = 13'h0000;
    localparam logic [PID_W-1:0]  PID_CAT   = 13'h0001;
    localparam logic [PID_W-1:0]  PID_SDT   = 13'h0011;

    // Input item kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Depth of the queue between classifier and emitter
    localparam int QUEUE_DEPTH = 4;

    // One queued job: either the three header bytes of a kept packet or one body byte
    typedef struct packed {
        logic              triple;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
        logic [OFFS_W-1:0] base;
        logic [IDX_W-1:0]  pos;
    } job_t;

    // Queue status seen by producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[rtl/tspf_if.sv]
// Channel interfaces of the PID filter: stream input, result output, register writes.
// Depends on tspf_pkg for field widths.
interface tspf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [tspf_pkg::BYTE_W-1:0] data_byte;
    logic                        sample_start;

    modport source (output valid, output kind, output data_byte, output sample_start,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input sample_start,
                    output ready);
endinterface

interface tspf_out_if;
    logic                        valid;
    logic                        ready;
    logic [tspf_pkg::BYTE_W-1:0] out_byte;
    logic [tspf_pkg::OFFS_W-1:0] file_offset;
    logic                        last_of_run;

    modport source (output valid, output out_byte, output file_offset,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input file_offset,
                    input last_of_run, output ready);
endinterface

interface tspf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tspf_pkg::CFG_IDX_W-1:0] index;
    logic [tspf_pkg::PIDREG_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ts_pid_packet_filter_top.sv]
// Top level of the transport-stream PID filter.
// Depends on tspf_pkg, tspf_if, tspf_front, tspf_queue and tspf_back.
//
// Usage:
//   in_ch  - stream beats: kind (byte or restart), data_byte, sample_start.
//   out_ch - result beats: out_byte, file_offset, last_of_run.
//   cfg    - register writes: index 0..7 selects a PID register, data is the
//            14-bit two's complement PID (negative matches nothing). Writes
//            are taken every cycle; higher indexes are ignored.
//   A stream beat is taken every cycle while the job queue has room. A kept
//   packet's third byte yields three results, every later byte one. The
//   emitter gives one result per cycle while out_ch is ready; a taken beat
//   is written into the queue at the accepting edge, then loaded into the
//   output register once that register is empty or being drained.
//   Throughput is one input byte per cycle while out_ch is ready; it is
//   bounded by the single result register, and the four-entry queue
//   absorbs the two extra header results of each kept packet.
//   Reset clears the packet position, decision, offset bases, queue and
//   output; PID registers return to -1.
//   When out_ch stalls the result is held, the queue fills, and in_ch.ready
//   falls once four jobs wait.
module ts_pid_packet_filter_top #(
    parameter int unsigned PACKET_BYTES = tspf_pkg::PACKET_BYTES_DEF,
    parameter logic [tspf_pkg::BASE_W-1:0] MAX_LENGTH = tspf_pkg::MAX_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tspf_in_if.sink     in_ch,
    tspf_out_if.source  out_ch,
    tspf_cfg_if.sink    cfg
);
    import tspf_pkg::*;

    logic      push;
    logic      pop;
    job_t      job;
    job_t      head;
    q_status_t status;

    assign in_ch.ready = !status.full;
    assign cfg.ready   = 1'b1;

    // Classifier
    tspf_front #(
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_ch.valid && in_ch.ready),
        .kind         (in_ch.kind),
        .data_byte    (in_ch.data_byte),
        .sample_start (in_ch.sample_start),
        .cfg_we       (cfg.valid && cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .push         (push),
        .job          (job)
    );

    // Job queue
    tspf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    // Emitter
    tspf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .status      (status),
        .pop         (pop),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_byte    (out_ch.out_byte),
        .file_offset (out_ch.file_offset),
        .last_of_run (out_ch.last_of_run)
    );

endmodule

[rtl/tspf_front.sv]
// Classifier: packet position, header hold, PID decision, offset bases, PID registers.
// Depends on tspf_pkg; pushes jobs into tspf_queue.
`include "assert_macros.svh"

module tspf_front #(
    parameter int unsigned PACKET_BYTES = tspf_pkg::PACKET_BYTES_DEF,
    parameter logic [tspf_pkg::BASE_W-1:0] MAX_LENGTH = tspf_pkg::MAX_LENGTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // stream beat, already qualified by the handshake
    input  logic                              accept,
    input  logic                              kind,
    input  logic [tspf_pkg::BYTE_W-1:0]       data_byte,
    input  logic                              sample_start,
    // register write beat
    input  logic                              cfg_we,
    input  logic [tspf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tspf_pkg::PIDREG_W-1:0]     cfg_data,
    // job to the queue
    output logic                              push,
    output tspf_pkg::job_t                    job
);
    import tspf_pkg::*;

    localparam logic [IDX_W:0]  LAST_IDX = (IDX_W+1)'(PACKET_BYTES - 1);
    localparam logic [BASE_W:0] MAX_EXT  = {1'b0, MAX_LENGTH};
    localparam logic [BASE_W:0] PKT_EXT  = (BASE_W+1)'(PACKET_BYTES);

    logic [PIDREG_W-1:0] pid_reg [PID_COUNT];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [BYTE_W-1:0]   hold0_reg, hold1_reg;
    logic                sync_reg, sync_next;
    logic                acc_reg, acc_next;
    logic [OFFS_W-1:0]   base_reg, base_next;
    logic [BASE_W-1:0]   nbase_reg, nbase_next;

    logic [IDX_W-1:0]    idx;
    logic [PID_W-1:0]    pid;
    logic                wanted;
    logic [BASE_W:0]     nb_sum;
    logic [BASE_W-1:0]   nb_wrapped;

    // PID registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PID_COUNT; i++)
            begin
                pid_reg[i] <= PID_DISABLED;
            end
        end
        else if (cfg_we && cfg_index < CFG_IDX_W'(PID_COUNT))
        begin
            pid_reg[cfg_index[$clog2(PID_COUNT)-1:0]] <= cfg_data;
        end
    end

    // Position within the packet; a sample start forces position zero
    assign idx = sample_start ? '0 : idx_reg;
    assign pid = {hold1_reg[4:0], data_byte};

    // PID match: fixed tables plus the eight registers (negative values never match)
    always_comb
    begin
        wanted = (pid == PID_PAT) || (pid == PID_CAT) || (pid == PID_SDT);
        for (int i = 0; i < PID_COUNT; i++)
        begin
            if (pid_reg[i] == {1'b0, pid})
            begin
                wanted = 1'b1;
            end
        end
    end

    // Base of the packet after this one
    assign nb_sum     = {1'b0, nbase_reg} + PKT_EXT;
    assign nb_wrapped = (nb_sum > MAX_EXT) ? '0 : nb_sum[BASE_W-1:0];

    // Per-beat state update and job build
    always_comb
    begin
        idx_next   = idx_reg;
        sync_next  = sync_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        nbase_next = nbase_reg;
        push       = 1'b0;
        job.triple = 1'b0;
        job.byte0  = hold0_reg;
        job.byte1  = hold1_reg;
        job.byte2  = data_byte;
        job.base   = base_reg;
        job.pos    = idx;

        if (accept)
        begin
            if (kind == KIND_RESTART)
            begin
                base_next  = '0;
                nbase_next = '0;
            end
            else
            begin
                if (idx == IDX_W'(0))
                begin
                    sync_next = (data_byte == SYNC_BYTE);
                    acc_next  = 1'b0;
                end
                else if (idx == IDX_W'(2))
                begin
                    acc_next = sync_reg && wanted;
                    if (sync_reg && wanted)
                    begin
                        base_next  = nbase_reg[OFFS_W-1:0];
                        nbase_next = nb_wrapped;
                        push       = 1'b1;
                        job.triple = 1'b1;
                        job.base   = nbase_reg[OFFS_W-1:0];
                    end
                end
                else if (idx != IDX_W'(1) && acc_reg)
                begin
                    push = 1'b1;
                end

                idx_next = ({1'b0, idx} >= LAST_IDX) ? '0 : idx + IDX_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            sync_reg  <= 1'b0;
            acc_reg   <= 1'b0;
            base_reg  <= '0;
            nbase_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            sync_reg  <= sync_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            nbase_reg <= nbase_next;
        end
    end

    // Held header bytes
    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_BYTE && idx == IDX_W'(0))
        begin
            hold0_reg <= data_byte;
        end
        if (accept && kind == KIND_BYTE && idx == IDX_W'(1))
        begin
            hold1_reg <= data_byte;
        end
    end

    `TSPF_ASSERT_CLK(a_idx_range, clk, rst_n, {1'b0, idx_reg} <= LAST_IDX)
    `TSPF_ASSERT_CLK(a_base_limit, clk, rst_n, {1'b0, nbase_reg} <= MAX_EXT)

endmodule

[rtl/tspf_queue.sv]
// Short job queue between classifier and emitter, flip-flop storage.
// Depends on tspf_pkg for the job and status types.
`include "assert_macros.svh"

module tspf_queue #(
    parameter int DEPTH = tspf_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tspf_pkg::job_t       push_job,
    input  logic                 pop,
    output tspf_pkg::job_t       head,
    output tspf_pkg::q_status_t  status
);
    import tspf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign head         = slot_reg[rd_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    `TSPF_ASSERT_CLK(a_no_overflow, clk, rst_n, push |-> !status.full)
    `TSPF_ASSERT_CLK(a_no_underflow, clk, rst_n, pop |-> !status.empty)

endmodule

[rtl/tspf_back.sv]
// Emitter: expands queued jobs into result beats through one output register.
// Depends on tspf_pkg; reads the head of tspf_queue.
`include "assert_macros.svh"

module tspf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tspf_pkg::job_t                 head,
    input  tspf_pkg::q_status_t            status,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tspf_pkg::BYTE_W-1:0]    out_byte,
    output logic [tspf_pkg::OFFS_W-1:0]    file_offset,
    output logic                           last_of_run
);
    import tspf_pkg::*;

    logic [1:0]        step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [OFFS_W-1:0] offs_reg, offs_next;
    logic              last_reg, last_next;
    logic              load;
    logic [IDX_W-1:0]  pos;

    // Output register may take a new beat when empty or being drained
    assign load = !valid_reg || out_ready;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        offs_next  = offs_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        pos        = head.triple ? IDX_W'(step_reg) : head.pos;

        if (load && !status.empty)
        begin
            pop        = !head.triple || step_reg == 2'd2;
            valid_next = 1'b1;
            last_next  = pop;
            offs_next  = head.base + OFFS_W'(pos);
            step_next  = pop ? 2'd0 : step_reg + 2'd1;
            case (step_reg)
                2'd0:    byte_next = head.triple ? head.byte0 : head.byte2;
                2'd1:    byte_next = head.byte1;
                default: byte_next = head.byte2;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        offs_reg <= offs_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign file_offset = offs_reg;
    assign last_of_run = last_reg;

    `TSPF_ASSERT_ALWAYS(a_step_range, clk, step_reg != 2'd3)
    `TSPF_ASSERT_CLK(a_step_has_job, clk, rst_n, (step_reg != 2'd0) |-> !status.empty)

endmodule

[sim/tb_ts_pid_packet_filter_top.sv]
// Self-checking testbench for ts_pid_packet_filter_top: stream beats, PID register writes
// and result back-pressure, with every result predicted by an in-bench packet filter model.
// Depends on tspf_pkg, the tspf channel interfaces and the filter RTL.
module tb_ts_pid_packet_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tspf_pkg::*;

    localparam int unsigned PKT_LEN = PACKET_BYTES_DEF;
    localparam logic [BASE_W-1:0] WRAP_LIMIT = MAX_LENGTH_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 1500;
    localparam int HOLD_CYCLES   = 90;
    localparam int MAX_GAP       = 13;
    localparam int MAX_REPORTS   = 60;

    // PID register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIDEO    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO1   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO2   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AC3      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TELETEXT = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUBTITLE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PMT      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PCR      = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 4'd15;

    typedef struct {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic              sos;
        int                gap;
    } stream_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic [OFFS_W-1:0] offset;
        logic              last;
    } kept_byte_t;

    logic clk;
    logic rst_n;

    tspf_in_if  in_ch();
    tspf_out_if out_ch();
    tspf_cfg_if cfg_ch();

    ts_pid_packet_filter_top #(
        .PACKET_BYTES (PKT_LEN),
        .MAX_LENGTH   (WRAP_LIMIT)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // Pending stream beats and expected kept bytes
    stream_beat_t stream_q[$];
    kept_byte_t   kept_bytes_q[$];
    stream_beat_t cur_beat;
    int           beats_queued;
    int           src_wait;
    int           snk_wait;
    int           err_cnt;
    bit           src_gaps_on;
    bit           snk_gaps_on;
    logic         sink_hold;
    event         hold_go;

    // Filter model state
    logic [PIDREG_W-1:0] pid_tab [PID_COUNT];
    logic [IDX_W-1:0]    byte_pos;
    logic [BYTE_W-1:0]   hdr [2];
    logic                sync_ok;
    logic                keep_pkt;
    logic [BASE_W-1:0]   cur_base;
    logic [BASE_W-1:0]   nxt_base;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic flag_mismatch(string msg);
        if (err_cnt < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic bit pid_wanted(logic [PID_W-1:0] pid);
        if (pid == PID_PAT || pid == PID_CAT || pid == PID_SDT)
            return 1'b1;
        foreach (pid_tab[i])
            if (pid_tab[i] == {1'b0, pid})
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void expect_byte(logic [BYTE_W-1:0] b, logic [IDX_W-1:0] pos,
                                        logic last);
        logic [BASE_W:0] off;
        kept_byte_t      r;
        off        = {1'b0, cur_base} + (BASE_W+1)'(pos);
        r.byte_val = b;
        r.offset   = off[OFFS_W-1:0];
        r.last     = last;
        kept_bytes_q.push_back(r);
    endfunction

    // Advance the filter model by one accepted stream beat
    function automatic void filter_step(stream_beat_t bt);
        logic [IDX_W-1:0] pos;
        logic [PID_W-1:0] pid;
        logic [BASE_W:0]  sum;
        if (bt.kind == KIND_RESTART)
        begin
            cur_base = '0;
            nxt_base = '0;
            return;
        end
        if (bt.sos)
            byte_pos = '0;
        pos = byte_pos;
        if (pos == IDX_W'(0))
        begin
            hdr[0]   = bt.data;
            sync_ok  = (bt.data == SYNC_BYTE);
            keep_pkt = 1'b0;
        end
        else if (pos == IDX_W'(1))
            hdr[1] = bt.data;
        else if (pos == IDX_W'(2))
        begin
            // PID decides; the two held header bytes go out with this one
            pid      = {hdr[1][4:0], bt.data};
            keep_pkt = sync_ok && pid_wanted(pid);
            if (keep_pkt)
            begin
                cur_base = nxt_base;
                sum      = {1'b0, nxt_base} + (BASE_W+1)'(PKT_LEN);
                nxt_base = (sum > {1'b0, WRAP_LIMIT}) ? '0 : sum[BASE_W-1:0];
                expect_byte(hdr[0], 8'd0, 1'b0);
                expect_byte(hdr[1], 8'd1, 1'b0);
                expect_byte(bt.data, 8'd2, 1'b1);
            end
        end
        else if (keep_pkt)
            expect_byte(bt.data, pos, 1'b1);
        byte_pos = (int'(pos) + 1 >= PKT_LEN) ? '0 : pos + IDX_W'(1);
    endfunction

    // Stream driver: one beat per handshake, per-beat gap before offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                filter_step(cur_beat);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (stream_q.size() != 0 && src_wait >= stream_q[0].gap)
                begin
                    cur_beat = stream_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.kind         <= cur_beat.kind;
                    in_ch.data_byte    <= cur_beat.data;
                    in_ch.sample_start <= cur_beat.sos;
                    src_wait = 0;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    if (stream_q.size() != 0)
                        src_wait++;
                end
            end
        end
    end

    task automatic check_result();
        kept_byte_t want;
        if (kept_bytes_q.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected result byte %h offset %0d",
                                    out_ch.out_byte, out_ch.file_offset));
            return;
        end
        want = kept_bytes_q.pop_front();
        if (out_ch.out_byte !== want.byte_val)
            flag_mismatch($sformatf("out_byte %h, expected %h",
                                    out_ch.out_byte, want.byte_val));
        if (out_ch.file_offset !== want.offset)
            flag_mismatch($sformatf("file_offset %0d, expected %0d",
                                    out_ch.file_offset, want.offset));
        if (out_ch.last_of_run !== want.last)
            flag_mismatch($sformatf("last_of_run %b, expected %b",
                                    out_ch.last_of_run, want.last));
    endtask

    // Result monitor with random per-beat stalls and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            snk_wait = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                check_result();
                snk_wait = snk_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (sink_hold)
                out_ch.ready <= 1'b0;
            else if (snk_wait > 0)
            begin
                snk_wait--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps pushing
    initial
    begin
        sink_hold = 1'b0;
        forever
        begin
            @(hold_go);
            @(posedge clk);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    // Watchdog: too long without any beat on any channel
    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic void push_beat(logic kind, logic [BYTE_W-1:0] data, logic sos);
        stream_beat_t bt;
        bt.kind = kind;
        bt.data = data;
        bt.sos  = sos;
        bt.gap  = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        stream_q.push_back(bt);
        beats_queued++;
    endfunction

    // Restart beat: data and sample start are don't-care, so randomize them
    function automatic void push_restart();
        logic [BYTE_W-1:0] junk;
        logic              junk_sos;
        junk     = BYTE_W'($urandom);
        junk_sos = 1'($urandom);
        push_beat(KIND_RESTART, junk, junk_sos);
    endfunction

    // PID for a well-formed packet: configured, fixed table PID, or anything
    function automatic logic [PID_W-1:0] pick_pid();
        int               r;
        int               slot;
        logic [PID_W-1:0] p;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            slot = $urandom_range(0, PID_COUNT - 1);
            if (!pid_tab[slot][PIDREG_W-1])
                return pid_tab[slot][PID_W-1:0];
        end
        if (r < 7)
        begin
            case ($urandom_range(0, 2))
                0:       return PID_PAT;
                1:       return PID_CAT;
                default: return PID_SDT;
            endcase
        end
        p = PID_W'($urandom);
        return p;
    endfunction

    // Mostly short well-formed packets cut by sample start, some noise and restarts
    task automatic queue_random(int n);
        int                target;
        int                len;
        int                sel;
        logic [PID_W-1:0]  pid;
        logic [2:0]        flags;
        logic [BYTE_W-1:0] b;
        target = beats_queued + n;
        while (beats_queued < target)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 8)
            begin
                pid = pick_pid();
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                   : $urandom_range(3, 12);
                for (int k = 0; k < len; k++)
                begin
                    flags = 3'($urandom);
                    b     = BYTE_W'($urandom);
                    case (k)
                        0:
                        begin
                            if ($urandom_range(0, 9) != 0)
                                b = SYNC_BYTE;
                        end
                        1:       b = {flags, pid[PID_W-1:8]};
                        2:       b = pid[7:0];
                        default: ;
                    endcase
                    push_beat(KIND_BYTE, b, k == 0);
                    if ($urandom_range(0, 39) == 0)
                        push_restart();
                end
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    b = BYTE_W'($urandom);
                    push_beat(KIND_BYTE, b, $urandom_range(0, 3) == 0);
                end
                if (sel == 9)
                    push_restart();
            end
        end
    endtask

    // Wait until the stream is sent and every kept byte has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (stream_q.size() != 0 || in_ch.valid || kept_bytes_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pid_reg(logic [CFG_IDX_W-1:0] idx, logic [PIDREG_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx < PID_COUNT)
            pid_tab[idx] = val;
    endtask

    task automatic load_pid_table(logic [PIDREG_W-1:0] vals [PID_COUNT]);
        for (int r = REG_VIDEO; r <= REG_PCR; r++)
            write_pid_reg(CFG_IDX_W'(r), vals[r]);
    endtask

    function automatic logic [PIDREG_W-1:0] rand_pid_reg();
        if ($urandom_range(0, 3) == 0)
            return PID_DISABLED;
        return PIDREG_W'($urandom_range(0, 8191));
    endfunction

    // Main sequence
    initial
    begin
        logic [PIDREG_W-1:0] tbl [PID_COUNT];

        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_BYTE;
        in_ch.data_byte    = '0;
        in_ch.sample_start = 1'b0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        src_gaps_on        = 1'b1;
        snk_gaps_on        = 1'b1;
        err_cnt            = 0;
        beats_queued       = 0;
        foreach (pid_tab[i])
            pid_tab[i] = PID_DISABLED;
        byte_pos = '0;
        hdr[0]   = '0;
        hdr[1]   = '0;
        sync_ok  = 1'b0;
        keep_pkt = 1'b0;
        cur_base = '0;
        nxt_base = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fixed PIDs under the reset table, all registers disabled
        push_beat(KIND_BYTE, SYNC_BYTE, 1'b1);
        push_beat(KIND_BYTE, {3'b000, PID_PAT[PID_W-1:8]}, 1'b0);
        push_beat(KIND_BYTE, PID_PAT[7:0], 1'b0);
        push_beat(KIND_BYTE, 8'hFF, 1'b0);
        // header flag bits set above the PID
        push_beat(KIND_BYTE, SYNC_BYTE, 1'b1);
        push_beat(KIND_BYTE, {3'b111, PID_CAT[PID_W-1:8]}, 1'b0);
        push_beat(KIND_BYTE, PID_CAT[7:0], 1'b0);
        push_beat(KIND_BYTE, 8'h00, 1'b0);
        // restart in mid-packet: the rest of the packet counts from base zero
        push_beat(KIND_BYTE, SYNC_BYTE, 1'b1);
        push_beat(KIND_BYTE, {3'b000, PID_SDT[PID_W-1:8]}, 1'b0);
        push_beat(KIND_BYTE, PID_SDT[7:0], 1'b0);
        push_restart();
        push_beat(KIND_BYTE, 8'h5A, 1'b0);
        // bad sync byte
        push_beat(KIND_BYTE, 8'h46, 1'b1);
        push_beat(KIND_BYTE, 8'h00, 1'b0);
        push_beat(KIND_BYTE, 8'h00, 1'b0);
        push_beat(KIND_BYTE, 8'h55, 1'b0);
        // top PID against all-disabled registers
        push_beat(KIND_BYTE, SYNC_BYTE, 1'b1);
        push_beat(KIND_BYTE, 8'h1F, 1'b0);
        push_beat(KIND_BYTE, 8'hFF, 1'b0);
        push_beat(KIND_BYTE, 8'h80, 1'b0);
        // short packet cut before the PID byte
        push_beat(KIND_BYTE, SYNC_BYTE, 1'b1);
        push_beat(KIND_BYTE, 8'h00, 1'b0);
        push_beat(KIND_RESTART, 8'hFF, 1'b1);
        wait_idle();

        // Extreme register values, plus a write to an unused index
        tbl = '{14'h1FFF, 14'h0100, 14'h0ABC, 14'h0000,
                14'h1555, 14'h0AAA, 14'h0030, PID_DISABLED};
        load_pid_table(tbl);
        write_pid_reg(REG_UNUSED, 14'h2AAA);
        queue_random(35);
        wait_idle();

        // Back-pressure: long receiver hold-off while the sender streams
        foreach (tbl[i])
            tbl[i] = rand_pid_reg();
        load_pid_table(tbl);
        src_gaps_on = 1'b0;
        -> hold_go;
        queue_random(40);
        // sender pauses until every result is back
        wait_idle();
        src_gaps_on = 1'b1;
        queue_random(25);
        wait_idle();

        // Full rate on both sides
        foreach (tbl[i])
            tbl[i] = rand_pid_reg();
        load_pid_table(tbl);
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        queue_random(20);
        wait_idle();

        // Back to all disabled
        foreach (tbl[i])
            tbl[i] = PID_DISABLED;
        load_pid_table(tbl);
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        queue_random(25);
        wait_idle();

        if (kept_bytes_q.size() != 0)
            flag_mismatch($sformatf("%0d expected results never came", kept_bytes_q.size()));
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
